// ===== src/olist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

  // List size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Width used when the 7-bit position field meets the count.
  localparam int CMPW = (CW > 7) ? CW : 7;
  // Cells per group of the registered read reduction.
  localparam int GRP = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  // Operation codes.
  localparam logic [3:0] OP_INS_START = 4'd0;
  localparam logic [3:0] OP_INS_END   = 4'd1;
  localparam logic [3:0] OP_INS_AT    = 4'd2;
  localparam logic [3:0] OP_DEL_START = 4'd3;
  localparam logic [3:0] OP_DEL_END   = 4'd4;
  localparam logic [3:0] OP_DEL_AT    = 4'd5;
  localparam logic [3:0] OP_DEL_VALUE = 4'd6;
  localparam logic [3:0] OP_FIND      = 4'd7;
  localparam logic [3:0] OP_READ      = 4'd8;
  localparam logic [3:0] OP_REVERSE   = 4'd9;
  localparam logic [3:0] OP_CLEAR     = 4'd10;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY
  } state_t;

  // Update command broadcast to every cell of the row.
  typedef struct packed {
    logic          ins;
    logic          del;
    logic [IW-1:0] pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/olist_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olist_cell (
  input  wire logic                     clk,
  input  wire logic [olist_pkg::IW-1:0] idx,
  input  wire olist_pkg::cell_ctl_t     ctl,
  input  wire logic [31:0]              key,
  input  wire logic [olist_pkg::CW-1:0] count,
  input  wire logic [olist_pkg::IW-1:0] rd_pos,
  input  wire logic [31:0]              from_left,
  input  wire logic [31:0]              from_right,
  output logic [31:0]                   entry,
  output logic                          match,
  output logic [31:0]                   rd_word
);
  import olist_pkg::*;

  // Insert opens a gap by taking the left neighbor; delete closes it from the right.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        entry <= key;
      end else if (idx > ctl.pos) begin
        entry <= from_left;
      end
    end else if (ctl.del && (idx >= ctl.pos)) begin
      entry <= from_right;
    end
  end

  // A cell matches only while it lies inside the list.
  assign match = (entry == key) && (CW'(idx) < count);

  // The selected cell drives its word into the read reduction.
  assign rd_word = (idx == rd_pos) ? entry : 32'd0;

endmodule

`default_nettype wire

// ===== src/ordered_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A taken word sits in the request registers; the look state registers the parallel
// compare and read across the cell row, and the apply state, waiting while the
// output stalls, shifts every cell and registers the result; a new word may enter then.
// Reset (rst, synchronous) empties the list and clears the output valid; the cell
// contents are not cleared and are never read before they are written.

module ordered_list_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  operation,
  input  wire logic [31:0] value,
  input  wire logic [6:0]  position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      read_value,
  output logic [5:0]       found_position,
  output logic [6:0]       entry_count
);
  import olist_pkg::*;

  // Lowest set bit of the match vector.
  function automatic logic [IW-1:0] first_set(input logic [CAPACITY-1:0] m);
    logic [IW-1:0] r;
    int i;
    r = '0;
    for (i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) r = IW'(i);
    end
    return r;
  endfunction

  // Highest set bit of the match vector.
  function automatic logic [IW-1:0] last_set(input logic [CAPACITY-1:0] m);
    logic [IW-1:0] r;
    int i;
    r = '0;
    for (i = 0; i < CAPACITY; i++) begin
      if (m[i]) r = IW'(i);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [3:0]          req_op;
  logic [31:0]         req_value;
  logic [6:0]          req_pos;
  logic [CW-1:0]       count, count_next;
  // Set when the list order runs from the highest occupied cell down to cell 0.
  logic                rev, rev_next;

  logic [31:0]         ent [CAPACITY];
  logic [31:0]         cell_rd [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_q;
  logic [31:0]         rd_part [NGRP];
  logic [31:0]         rd_part_q [NGRP];
  logic [IW-1:0]       rd_phys;
  cell_ctl_t           ctl, ctl_gated;

  logic                out_free, take_in, apply_fire;
  logic [1:0]          st_c;
  logic [31:0]         rd_c, rd_all;
  logic [5:0]          fp_c;
  logic [CMPW-1:0]     n_w, p_w, l_w, cap_w;
  logic [IW-1:0]       lo_idx, hi_idx, m_phys;
  logic                any_match;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == S_IDLE) || ((state == S_APPLY) && out_free));
  assign take_in    = in_valid && !in_stall;
  assign apply_fire = (state == S_APPLY) && out_free;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: look, then apply; a new word may enter as a result leaves.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (take_in) state_next = S_LOOK;
      S_LOOK:  state_next = S_APPLY;
      S_APPLY: begin
        if (apply_fire) state_next = take_in ? S_LOOK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (take_in) begin
      req_op    <= operation;
      req_value <= value;
      req_pos   <= position;
    end
  end

  assign n_w   = CMPW'(count);
  assign p_w   = CMPW'(req_pos);
  assign cap_w = CMPW'(CAPACITY);

  // Physical cell addressed by a read, honoring the direction flag.
  assign rd_phys = rev ? IW'(n_w - CMPW'(1) - p_w) : IW'(p_w);

  // The cell row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ent[0];
    end else begin : g_mid
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ent[i];
    end else begin : g_inner
      assign right_w = ent[i+1];
    end
    olist_cell u_cell (
      .clk        (clk),
      .idx        (IW'(i)),
      .ctl        (ctl_gated),
      .key        (req_value),
      .count      (count),
      .rd_pos     (rd_phys),
      .from_left  (left_w),
      .from_right (right_w),
      .entry      (ent[i]),
      .match      (cell_match[i]),
      .rd_word    (cell_rd[i])
    );
  end

  // First level of the read reduction: one OR per group of cells.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      rd_part[g] = 32'd0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) rd_part[g] = rd_part[g] | cell_rd[g * GRP + k];
      end
    end
  end

  // Look stage registers the compare results and the partial reads.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      match_q <= cell_match;
      for (int g = 0; g < NGRP; g++) begin
        rd_part_q[g] <= rd_part[g];
      end
    end
  end

  // Final read OR over the registered groups.
  always_comb begin
    rd_all = 32'd0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | rd_part_q[g];
    end
  end

  assign lo_idx    = first_set(match_q);
  assign hi_idx    = last_set(match_q);
  assign any_match = |match_q;
  // First match in list order is the lowest cell, or the highest when reversed.
  assign m_phys    = rev ? hi_idx : lo_idx;

  // Apply stage: decide the result and the row update.
  always_comb begin
    st_c       = ST_OK;
    rd_c       = 32'd0;
    fp_c       = 6'd0;
    count_next = count;
    rev_next   = rev;
    ctl        = '0;
    l_w        = '0;
    case (req_op)
      OP_INS_START, OP_INS_END, OP_INS_AT: begin
        if (req_op == OP_INS_START) begin
          l_w = '0;
        end else if (req_op == OP_INS_END) begin
          l_w = n_w;
        end else begin
          l_w = p_w;
        end
        if ((n_w >= cap_w) || (l_w > n_w)) begin
          st_c = ST_REJECT;
        end else begin
          ctl.ins    = 1'b1;
          ctl.pos    = rev ? IW'(n_w - l_w) : IW'(l_w);
          count_next = count + CW'(1);
        end
      end
      OP_DEL_START, OP_DEL_END, OP_DEL_AT: begin
        if (req_op == OP_DEL_START) begin
          l_w = '0;
        end else if (req_op == OP_DEL_END) begin
          l_w = n_w - CMPW'(1);
        end else begin
          l_w = p_w;
        end
        if ((n_w == '0) || ((req_op == OP_DEL_AT) && (p_w >= n_w))) begin
          st_c = ST_REJECT;
        end else begin
          ctl.del    = 1'b1;
          ctl.pos    = rev ? IW'(n_w - CMPW'(1) - l_w) : IW'(l_w);
          count_next = count - CW'(1);
        end
      end
      OP_DEL_VALUE: begin
        if (n_w == '0) begin
          st_c = ST_REJECT;
        end else if (!any_match) begin
          st_c = ST_NOTFOUND;
        end else begin
          ctl.del    = 1'b1;
          ctl.pos    = m_phys;
          count_next = count - CW'(1);
        end
      end
      OP_FIND: begin
        if (!any_match) begin
          st_c = ST_NOTFOUND;
        end else begin
          fp_c = rev ? 6'(n_w - CMPW'(1) - CMPW'(hi_idx)) : 6'(lo_idx);
        end
      end
      OP_READ: begin
        if (p_w >= n_w) begin
          st_c = ST_REJECT;
        end else begin
          rd_c = rd_all;
        end
      end
      OP_REVERSE: begin
        rev_next = !rev;
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        st_c = ST_REJECT;
      end
    endcase
  end

  // The row only moves when the result is actually handed out.
  always_comb begin
    ctl_gated     = ctl;
    ctl_gated.ins = ctl.ins && apply_fire;
    ctl_gated.del = ctl.del && apply_fire;
  end

  // List bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rev   <= 1'b0;
    end else if (apply_fire) begin
      count <= count_next;
      rev   <= rev_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status         <= st_c;
      read_value     <= rd_c;
      found_position <= fp_c;
      entry_count    <= 7'(count_next);
    end
  end

endmodule

`default_nettype wire

// ===== src/olist_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olist_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [31:0] read_value,
  input wire logic [5:0]  found_position,
  input wire logic [6:0]  entry_count
);
  import olist_pkg::*;

  // A held result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(found_position) && $stable(entry_count))
    else $error("result word changed while stalled");

  // The block is busy for the cycle after it takes a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // The count never exceeds the list size.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 7'(CAPACITY))
    else $error("entry count above capacity");

  // Anything but success carries zero read data and position.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_value == 32'd0 && found_position == 6'd0)
    else $error("failed operation returned data");

  // Only the three defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_REJECT || status == ST_NOTFOUND)
    else $error("undefined status code");

endmodule

bind ordered_list_engine olist_chk u_olist_chk (.*);

`default_nettype wire

// ===== bench/ordered_list_engine_test.sv =====
`timescale 1ns / 1ps

module ordered_list_engine_test;
  import olist_pkg::*;

  // Codes the block leaves unused; they must be rejected.
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

  // Operation mixes of the random traffic, rotated every burst.
  localparam int MIX_FILL     = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN    = 2;
  localparam int BURST_WORDS  = 100;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [5:0]  found_position;
    logic [6:0]  entry_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  operation = 4'd0;
  logic [31:0] value = 32'd0;
  logic [6:0]  position = 7'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [5:0]  found_position;
  logic [6:0]  entry_count;

  // Shadow copy of the list kept in step with accepted words.
  logic [31:0]  list_entries [0:CAPACITY-1];
  int           list_count = 0;
  list_result_t pending_results [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int traffic_words = 0;

  ordered_list_engine dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shift later entries up and place the new one; false when it cannot go in.
  function automatic bit insert_entry(int at, logic [31:0] val);
    int i;
    if (list_count >= CAPACITY || at > list_count) return 1'b0;
    for (i = list_count; i > at; i--) list_entries[i] = list_entries[i-1];
    list_entries[at] = val;
    list_count++;
    return 1'b1;
  endfunction

  // Shift later entries down over the removed one.
  function automatic bit remove_entry(int at);
    int i;
    if (at >= list_count) return 1'b0;
    for (i = at; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
    list_count--;
    return 1'b1;
  endfunction

  // Index of the first entry equal to val, or the count when there is none.
  function automatic int find_entry(logic [31:0] val);
    int i;
    for (i = 0; i < list_count; i++) begin
      if (list_entries[i] == val) return i;
    end
    return list_count;
  endfunction

  // Apply one word to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_word(logic [3:0] op, logic [31:0] val,
                                                   logic [6:0] pos);
    list_result_t r;
    int k;
    int i;
    logic [31:0] t;
    r.status = ST_OK;
    r.read_value = 32'd0;
    r.found_position = 6'd0;
    case (op)
      OP_INS_START: if (!insert_entry(0, val)) r.status = ST_REJECT;
      OP_INS_END:   if (!insert_entry(list_count, val)) r.status = ST_REJECT;
      OP_INS_AT:    if (!insert_entry(int'(pos), val)) r.status = ST_REJECT;
      OP_DEL_START: if (!remove_entry(0)) r.status = ST_REJECT;
      OP_DEL_END: begin
        if (list_count == 0 || !remove_entry(list_count - 1)) r.status = ST_REJECT;
      end
      OP_DEL_AT:    if (!remove_entry(int'(pos))) r.status = ST_REJECT;
      OP_DEL_VALUE: begin
        if (list_count == 0) begin
          r.status = ST_REJECT;
        end else begin
          k = find_entry(val);
          if (k < list_count) void'(remove_entry(k));
          else r.status = ST_NOTFOUND;
        end
      end
      OP_FIND: begin
        k = find_entry(val);
        if (k < list_count) r.found_position = k[5:0];
        else r.status = ST_NOTFOUND;
      end
      OP_READ: begin
        if (int'(pos) < list_count) r.read_value = list_entries[pos];
        else r.status = ST_REJECT;
      end
      OP_REVERSE: begin
        for (i = 0; i < list_count / 2; i++) begin
          t = list_entries[i];
          list_entries[i] = list_entries[list_count-1-i];
          list_entries[list_count-1-i] = t;
        end
      end
      OP_CLEAR: list_count = 0;
      default: r.status = ST_REJECT;
    endcase
    r.entry_count = list_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word, predict its result once it is taken, then maybe go idle.
  task automatic send_word(input logic [3:0] op, input logic [31:0] val,
                           input logic [6:0] pos);
    operation <= op;
    value <= val;
    position <= pos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_word(op, val, pos));
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
  endtask

  // The receiver stalls at random at the chosen rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no word pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %h want %h",
                                    read_value, want.read_value));
        if (found_position !== want.found_position)
          report_mismatch($sformatf("found_position got %0d want %0d",
                                    found_position, want.found_position));
        if (entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    entry_count, want.entry_count));
      end
    end
  end

  // Every removal, search and read, and a reverse, on an empty list.
  task automatic test_empty_list();
    send_word(OP_DEL_START, 32'd0, 7'd0);
    send_word(OP_DEL_END, 32'd0, 7'd0);
    send_word(OP_DEL_AT, 32'd0, 7'd0);
    send_word(OP_DEL_VALUE, 32'd0, 7'd0);
    send_word(OP_FIND, 32'd0, 7'd0);
    send_word(OP_READ, 32'd0, 7'd0);
    send_word(OP_REVERSE, 32'd0, 7'd0);
  endtask

  // Inserts at each place with extreme values, and reads at the edges.
  task automatic test_insert_read();
    send_word(OP_INS_END, 32'h7fff_ffff, 7'd0);
    send_word(OP_INS_START, 32'h8000_0000, 7'd0);
    send_word(OP_INS_AT, 32'd0, 7'd1);
    send_word(OP_INS_AT, 32'h1234_5678, 7'd4);
    send_word(OP_INS_AT, 32'hffff_ffff, 7'd3);
    send_word(OP_READ, 32'd0, 7'd0);
    send_word(OP_READ, 32'd0, 7'd3);
    send_word(OP_READ, 32'd0, 7'd4);
    send_word(OP_READ, 32'd0, 7'd127);
  endtask

  // Searches and removals that hit, miss or point past the end.
  task automatic test_search_delete();
    send_word(OP_FIND, 32'hffff_ffff, 7'd0);
    send_word(OP_FIND, 32'd12345, 7'd0);
    send_word(OP_DEL_VALUE, 32'd12345, 7'd0);
    send_word(OP_DEL_VALUE, 32'd0, 7'd0);
    send_word(OP_DEL_AT, 32'd0, 7'd64);
    send_word(OP_DEL_AT, 32'd0, 7'd1);
  endtask

  // An insert, a reverse and a read, an unused code with every bit set, then clear.
  task automatic test_reverse_clear();
    send_word(OP_INS_END, 32'd7, 7'd0);
    send_word(OP_REVERSE, 32'd0, 7'd0);
    send_word(OP_READ, 32'd0, 7'd0);
    send_word(OP_LAST_UNUSED, 32'hffff_ffff, 7'd127);
    send_word(OP_CLEAR, 32'd0, 7'd0);
  endtask

  // Random words in bursts that fill, churn or drain the list.
  task automatic test_random_traffic(input int words, input int idle, input int stall);
    int n;
    int mode;
    int pick;
    int ins_share;
    int del_share;
    logic [3:0] op;
    logic [31:0] val;
    logic [6:0] pos;
    send_idle_pct = idle;
    stall_pct = stall;
    for (n = 0; n < words; n++) begin
      mode = (traffic_words / BURST_WORDS) % 3;
      traffic_words++;
      ins_share = (mode == MIX_FILL) ? 80 : (mode == MIX_DRAIN) ? 10 : 35;
      del_share = (mode == MIX_FILL) ? 10 : (mode == MIX_DRAIN) ? 70 : 35;
      pick = $urandom_range(99);
      if (pick < ins_share) begin
        case ($urandom_range(2))
          0: op = OP_INS_START;
          1: op = OP_INS_END;
          default: op = OP_INS_AT;
        endcase
      end else if (pick < ins_share + del_share) begin
        case ($urandom_range(3))
          0: op = OP_DEL_START;
          1: op = OP_DEL_END;
          2: op = OP_DEL_AT;
          default: op = OP_DEL_VALUE;
        endcase
      end else if (pick < 95) begin
        op = $urandom_range(1) ? OP_FIND : OP_READ;
      end else begin
        case ($urandom_range(5))
          0, 1: op = OP_REVERSE;
          2: op = OP_CLEAR;
          default: op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        endcase
      end
      // Values often repeat what is stored so that searches hit.
      case ($urandom_range(3))
        0: val = (list_count > 0) ? list_entries[$urandom_range(list_count - 1)]
                                  : $urandom;
        1: val = 32'($urandom_range(15)) - 32'd8;
        2: val = $urandom;
        default: val = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
      pos = ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                     : 7'($urandom_range(list_count));
      send_word(op, val, pos);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_list();
    test_insert_read();
    test_search_delete();
    test_reverse_clear();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 78, 0);
    test_random_traffic(200, 0, 78);
    test_random_traffic(200, 30, 30);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ordered_list_engine_test passed");
    end else begin
      $display("ordered_list_engine_test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("ordered_list_engine_test failed");
    $finish;
  end

endmodule

// ===== ordered_list_engine.f =====
src/olist_pkg.sv
src/olist_cell.sv
src/ordered_list_engine.sv
src/olist_chk.sv
bench/ordered_list_engine_test.sv
